// ----- src/assert_macros.svh -----
// Assertion macros for the task scheduler block.
// Needs signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CPTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define CPTS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- src/cpts_pkg.sv -----
// Shared types and constants of the counter priority task scheduler.
// No dependencies; used by the channel interfaces and the top level.
package cpts_pkg;

   localparam int MAX_TASKS      = 16;
   localparam int IDX_W          = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SLOT_W         = 4;
   localparam int OP_W           = 3;
   localparam int STATUS_W       = 2;
   localparam int PRIO_W         = 8;
   localparam int CNT_W          = 12;
   localparam int PRE_W          = 8;
   localparam int RECHARGE_LIMIT = 12;
   localparam int PASS_W         = $clog2(RECHARGE_LIMIT + 1);

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [PRIO_W-1:0]        prio_type;
   typedef logic signed [CNT_W-1:0]  cnt_type;
   typedef logic [PRE_W-1:0]         pre_type;

   localparam cnt_type  CNT_MIN     = {1'b1, {(CNT_W-1){1'b0}}};
   localparam cnt_type  CNT_NEG_ONE = '1;
   localparam cnt_type  CNT_ONE     = cnt_type'(1);
   localparam pre_type  PRE_MAX     = '1;
   localparam prio_type BOOT_PRIO_RESET = prio_type'(1);

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_STARTING = 2'd1,
      ST_RUNNING  = 2'd2,
      ST_ZOMBIE   = 2'd3
   } slot_state_type;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 3'd0,
      OP_YIELD    = 3'd1,
      OP_CREATE   = 3'd2,
      OP_EXIT     = 3'd3,
      OP_PRE_DIS  = 3'd4,
      OP_PRE_EN   = 3'd5,
      OP_READ     = 3'd6
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_NONE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TICK,
      S_CR_PRIO,
      S_CR_SCAN,
      S_CR_WR,
      S_EXIT,
      S_PRE_UP,
      S_PRE_DN,
      S_READ,
      S_SCAN,
      S_CHECK,
      S_RECHARGE,
      S_SW_OUT,
      S_SW_IN,
      S_DONE
   } sched_state_type;

endpackage

// ----- src/cpts_if.sv -----
// Valid/ready channel interfaces of the task scheduler: request, response, CSR.
// Depends on cpts_pkg for field widths.
interface cpts_req_if;
   import cpts_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [SLOT_W-1:0]   slot_select;
   modport source (output valid, output opcode, output slot_select, input ready);
   modport sink   (input valid, input opcode, input slot_select, output ready);
endinterface

interface cpts_rsp_if;
   import cpts_pkg::*;
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   running_slot;
   logic                switched;
   logic [SLOT_W-1:0]   created_slot;
   logic [STATUS_W-1:0] status;
   logic [1:0]          entry_state;
   logic [PRIO_W-1:0]   entry_priority;
   logic signed [CNT_W-1:0] entry_counter;
   logic [PRE_W-1:0]    entry_preempt;
   modport source (output valid, output running_slot, output switched, output created_slot,
                   output status, output entry_state, output entry_priority,
                   output entry_counter, output entry_preempt, input ready);
   modport sink   (input valid, input running_slot, input switched, input created_slot,
                   input status, input entry_state, input entry_priority,
                   input entry_counter, input entry_preempt, output ready);
endinterface

interface cpts_csr_if;
   import cpts_pkg::*;
   logic                valid;
   logic                ready;
   logic [PRIO_W-1:0]   boot_priority;
   modport source (output valid, output boot_priority, input ready);
   modport sink   (input valid, input boot_priority, output ready);
endinterface

// ----- src/counter_priority_task_scheduler_unit.sv -----
// Counter priority task scheduler: task table, sequencer and shared adder.
// Depends on cpts_pkg, cpts_if.sv and assert_macros.svh.
//
// Usage:
//  - req_chan carries one request (opcode, slot_select); it is taken only while the
//    sequencer is idle. rsp_chan returns exactly one response per request.
//  - csr_chan writes boot_priority, which reloads slot 0 priority and counter; it is
//    always ready and is meant to be written while no request is in flight.
//  - Every request walks the task table through one read/write port and one shared
//    12-bit adder. Tick without reschedule, preempt ops and read entry access one
//    table entry; an unused opcode goes straight to the response.
//    create: free slot search, one slot per cycle, then the write; status full if none.
//    schedule: yield, exit or expiring tick scan all slots once, plus a recharge pass
//    and rescan per retry (at most 12 passes), plus switch-out and switch-in steps.
//  - One request is in flight at a time; the next request may enter while the
//    previous response still waits in the output register.
//  - A stalled rsp_chan holds the response; a finished request then waits in its
//    last step until the output register frees up.
//  - Synchronous reset: slot 0 running with priority and counter 1, other slots
//    free, current slot 0, no response pending.
`include "assert_macros.svh"

module counter_priority_task_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   cpts_csr_if.sink    csr_chan,
   cpts_req_if.sink    req_chan,
   cpts_rsp_if.source  rsp_chan
);
   import cpts_pkg::*;

   // control
   sched_state_type state_ff, state_in;
   idx_type         cur_ff, cur_in;
   idx_type         idx_ff, idx_in;
   idx_type         pick_ff, pick_in;
   cnt_type         best_ff, best_in;
   logic            any_ff, any_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [SLOT_W-1:0] sel_ff, sel_in;
   prio_type        cap_prio_ff, cap_prio_in;

   // task table
   slot_state_type  slot_state_ff [MAX_TASKS];
   prio_type        slot_prio_ff  [MAX_TASKS];
   cnt_type         slot_cnt_ff   [MAX_TASKS];
   pre_type         slot_pre_ff   [MAX_TASKS];

   // result being built
   logic            res_sw_ff, res_sw_in;
   idx_type         res_created_ff, res_created_in;
   status_type      res_status_ff, res_status_in;
   slot_state_type  res_e_state_ff, res_e_state_in;
   prio_type        res_e_prio_ff, res_e_prio_in;
   cnt_type         res_e_cnt_ff, res_e_cnt_in;
   pre_type         res_e_pre_ff, res_e_pre_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_sw_ff;
   logic [SLOT_W-1:0] rsp_created_ff;
   status_type        rsp_status_ff;
   slot_state_type    rsp_e_state_ff;
   prio_type          rsp_e_prio_ff;
   cnt_type           rsp_e_cnt_ff;
   pre_type           rsp_e_pre_ff;

   // table port and adder
   idx_type         addr;
   slot_state_type  rd_state;
   prio_type        rd_prio;
   cnt_type         rd_cnt;
   pre_type         rd_pre;
   logic            we_state, we_prio, we_cnt, we_pre;
   slot_state_type  wd_state;
   prio_type        wd_prio;
   cnt_type         wd_cnt;
   pre_type         wd_pre;
   cnt_type         alu_a, alu_b, alu_sum;

   logic            req_acc, csr_acc, rsp_free, rsp_load;
   logic            last_idx, runnable, sel_in_range, tick_keep;
   idx_type         sel_idx;
   cnt_type         tick_dec;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign csr_acc  = csr_chan.valid && csr_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // table address
   always_comb begin
      case (state_ff)
         S_CR_SCAN, S_CR_WR, S_SCAN, S_RECHARGE: addr = idx_ff;
         S_READ:  addr = sel_idx;
         S_SW_IN: addr = pick_ff;
         default: addr = cur_ff;
      endcase
   end

   assign rd_state = slot_state_ff[addr];
   assign rd_prio  = slot_prio_ff[addr];
   assign rd_cnt   = slot_cnt_ff[addr];
   assign rd_pre   = slot_pre_ff[addr];

   assign last_idx     = (idx_ff == idx_type'(MAX_TASKS - 1));
   assign runnable     = (rd_state == ST_STARTING) || (rd_state == ST_RUNNING);
   assign sel_in_range = (int'(sel_ff) < MAX_TASKS);
   assign sel_idx      = idx_type'(sel_ff);

   assign alu_sum   = alu_a + alu_b;
   // counter sticks at its minimum
   assign tick_dec  = (rd_cnt == CNT_MIN) ? rd_cnt : alu_sum;
   assign tick_keep = (tick_dec > 0) || (rd_pre != '0);

   // shared adder operands
   always_comb begin
      alu_a = rd_cnt;
      alu_b = '0;
      case (state_ff)
         S_TICK: begin
            alu_a = rd_cnt;
            alu_b = CNT_NEG_ONE;
         end
         S_RECHARGE: begin
            alu_a = rd_cnt >>> 1;
            alu_b = cnt_type'({{(CNT_W-PRIO_W){1'b0}}, rd_prio});
         end
         S_PRE_UP, S_SW_OUT: begin
            alu_a = cnt_type'({{(CNT_W-PRE_W){1'b0}}, rd_pre});
            alu_b = CNT_ONE;
         end
         S_PRE_DN, S_SW_IN: begin
            alu_a = cnt_type'({{(CNT_W-PRE_W){1'b0}}, rd_pre});
            alu_b = CNT_NEG_ONE;
         end
         default: begin
            alu_a = rd_cnt;
            alu_b = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (opcode_type'(req_chan.opcode))
                  OP_TICK:    state_in = S_TICK;
                  OP_YIELD:   state_in = S_SCAN;
                  OP_CREATE:  state_in = S_CR_PRIO;
                  OP_EXIT:    state_in = S_EXIT;
                  OP_PRE_DIS: state_in = S_PRE_UP;
                  OP_PRE_EN:  state_in = S_PRE_DN;
                  OP_READ:    state_in = S_READ;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_TICK:    state_in = tick_keep ? S_DONE : S_SCAN;
         S_CR_PRIO: state_in = S_CR_SCAN;
         S_CR_SCAN: begin
            if (rd_state == ST_FREE)
               state_in = S_CR_WR;
            else if (last_idx)
               state_in = S_DONE;
         end
         S_CR_WR:   state_in = S_DONE;
         S_EXIT:    state_in = S_SCAN;
         S_PRE_UP:  state_in = S_DONE;
         S_PRE_DN:  state_in = S_DONE;
         S_READ:    state_in = S_DONE;
         S_SCAN:    state_in = last_idx ? S_CHECK : S_SCAN;
         S_CHECK: begin
            if (!any_ff)
               state_in = S_DONE;
            else if (best_ff > 0)
               state_in = (pick_ff != cur_ff) ? S_SW_OUT : S_DONE;
            else if (pass_ff >= PASS_W'(RECHARGE_LIMIT))
               state_in = S_DONE;
            else
               state_in = S_RECHARGE;
         end
         S_RECHARGE: state_in = last_idx ? S_SCAN : S_RECHARGE;
         S_SW_OUT:   state_in = S_SW_IN;
         S_SW_IN:    state_in = S_DONE;
         S_DONE:     state_in = rsp_free ? S_IDLE : S_DONE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath control and table writes
   always_comb begin
      cur_in         = cur_ff;
      idx_in         = idx_ff;
      pick_in        = pick_ff;
      best_in        = best_ff;
      any_in         = any_ff;
      pass_in        = pass_ff;
      sel_in         = sel_ff;
      cap_prio_in    = cap_prio_ff;
      res_sw_in      = res_sw_ff;
      res_created_in = res_created_ff;
      res_status_in  = res_status_ff;
      res_e_state_in = res_e_state_ff;
      res_e_prio_in  = res_e_prio_ff;
      res_e_cnt_in   = res_e_cnt_ff;
      res_e_pre_in   = res_e_pre_ff;
      rsp_load       = 1'b0;
      we_state       = 1'b0;
      we_prio        = 1'b0;
      we_cnt         = 1'b0;
      we_pre         = 1'b0;
      wd_state       = ST_RUNNING;
      wd_prio        = cap_prio_ff;
      wd_cnt         = alu_sum;
      wd_pre         = alu_sum[PRE_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               sel_in         = req_chan.slot_select;
               idx_in         = '0;
               pick_in        = '0;
               best_in        = CNT_NEG_ONE;
               any_in         = 1'b0;
               pass_in        = '0;
               res_sw_in      = 1'b0;
               res_created_in = '0;
               res_status_in  = STAT_OK;
               res_e_state_in = ST_FREE;
               res_e_prio_in  = '0;
               res_e_cnt_in   = '0;
               res_e_pre_in   = '0;
            end
         end
         S_TICK: begin
            we_cnt = 1'b1;
            wd_cnt = tick_keep ? tick_dec : '0;
         end
         S_CR_PRIO: cap_prio_in = rd_prio;
         S_CR_SCAN: begin
            if (rd_state != ST_FREE) begin
               if (last_idx)
                  res_status_in = STAT_FULL;
               else
                  idx_in = idx_ff + idx_type'(1);
            end
         end
         S_CR_WR: begin
            we_state       = 1'b1;
            wd_state       = ST_STARTING;
            we_prio        = 1'b1;
            wd_prio        = cap_prio_ff;
            we_cnt         = 1'b1;
            wd_cnt         = cnt_type'({{(CNT_W-PRIO_W){1'b0}}, cap_prio_ff});
            we_pre         = 1'b1;
            wd_pre         = pre_type'(1);
            res_created_in = idx_ff;
         end
         S_EXIT: begin
            we_state = 1'b1;
            wd_state = ST_ZOMBIE;
         end
         S_PRE_UP, S_SW_OUT: we_pre = (rd_pre != PRE_MAX);
         S_PRE_DN: we_pre = (rd_pre != '0);
         S_READ: begin
            if (sel_in_range) begin
               res_e_state_in = rd_state;
               res_e_prio_in  = rd_prio;
               res_e_cnt_in   = rd_cnt;
               res_e_pre_in   = rd_pre;
            end
         end
         S_SCAN: begin
            if (runnable) begin
               any_in = 1'b1;
               // strict compare keeps the lowest slot on ties
               if (rd_cnt > best_ff) begin
                  best_in = rd_cnt;
                  pick_in = idx_ff;
               end
            end
            if (!last_idx)
               idx_in = idx_ff + idx_type'(1);
         end
         S_CHECK: begin
            if (!any_ff)
               res_status_in = STAT_NONE;
            else if (best_ff > 0) begin
               // pick found
            end else if (pass_ff >= PASS_W'(RECHARGE_LIMIT))
               res_status_in = STAT_NONE;
            else begin
               pass_in = pass_ff + PASS_W'(1);
               idx_in  = '0;
            end
         end
         S_RECHARGE: begin
            we_cnt = (rd_state != ST_FREE);
            wd_cnt = alu_sum;
            if (last_idx) begin
               idx_in  = '0;
               best_in = CNT_NEG_ONE;
               any_in  = 1'b0;
            end else
               idx_in = idx_ff + idx_type'(1);
         end
         S_SW_IN: begin
            we_state  = 1'b1;
            wd_state  = ST_RUNNING;
            we_pre    = (rd_pre != '0);
            cur_in    = pick_ff;
            res_sw_in = 1'b1;
         end
         S_DONE: rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pick_ff        <= pick_in;
      best_ff        <= best_in;
      any_ff         <= any_in;
      sel_ff         <= sel_in;
      cap_prio_ff    <= cap_prio_in;
      res_sw_ff      <= res_sw_in;
      res_created_ff <= res_created_in;
      res_status_ff  <= res_status_in;
      res_e_state_ff <= res_e_state_in;
      res_e_prio_ff  <= res_e_prio_in;
      res_e_cnt_ff   <= res_e_cnt_in;
      res_e_pre_ff   <= res_e_pre_in;
      if (rsp_load) begin
         rsp_slot_ff    <= SLOT_W'(cur_ff);
         rsp_sw_ff      <= res_sw_ff;
         rsp_created_ff <= SLOT_W'(res_created_ff);
         rsp_status_ff  <= res_status_ff;
         rsp_e_state_ff <= res_e_state_ff;
         rsp_e_prio_ff  <= res_e_prio_ff;
         rsp_e_cnt_ff   <= res_e_cnt_ff;
         rsp_e_pre_ff   <= res_e_pre_ff;
      end
   end

   // task table: one port for the sequencer, slot 0 reload from the CSR
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            slot_state_ff[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
            slot_prio_ff[i]  <= (i == 0) ? BOOT_PRIO_RESET : '0;
            slot_cnt_ff[i]   <= (i == 0) ?
                                cnt_type'({{(CNT_W-PRIO_W){1'b0}}, BOOT_PRIO_RESET}) : '0;
            slot_pre_ff[i]   <= '0;
         end
      end else begin
         if (csr_acc) begin
            slot_prio_ff[0] <= csr_chan.boot_priority;
            slot_cnt_ff[0]  <= cnt_type'({{(CNT_W-PRIO_W){1'b0}}, csr_chan.boot_priority});
         end
         if (we_state) slot_state_ff[addr] <= wd_state;
         if (we_prio)  slot_prio_ff[addr]  <= wd_prio;
         if (we_cnt)   slot_cnt_ff[addr]   <= wd_cnt;
         if (we_pre)   slot_pre_ff[addr]   <= wd_pre;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.running_slot   = rsp_slot_ff;
   assign rsp_chan.switched       = rsp_sw_ff;
   assign rsp_chan.created_slot   = rsp_created_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.entry_state    = rsp_e_state_ff;
   assign rsp_chan.entry_priority = rsp_e_prio_ff;
   assign rsp_chan.entry_counter  = rsp_e_cnt_ff;
   assign rsp_chan.entry_preempt  = rsp_e_pre_ff;

   `CPTS_ASSERT(a_cur_moves_on_switch, (cur_ff != $past(cur_ff)) |-> ($past(state_ff) == S_SW_IN), "current slot changed outside a switch")
   `CPTS_ASSERT(a_pass_bound, pass_ff <= PASS_W'(RECHARGE_LIMIT), "recharge pass count out of range")
   `CPTS_ASSERT(a_cur_alive, (state_ff == S_IDLE) |-> (slot_state_ff[cur_ff] == ST_RUNNING || slot_state_ff[cur_ff] == ST_ZOMBIE), "current slot neither running nor zombie")
   `CPTS_ASSERT_NEXT(a_switch_marks_running, state_ff == S_SW_IN, slot_state_ff[cur_ff] == ST_RUNNING && res_sw_ff, "switched-in slot not running")

endmodule
